@@ rtl/taylor_series_evaluator_defines.svh @@
// assertion macros shared by the taylor series evaluator rtl
// no dependencies; included by the modules that carry assertions
`ifndef TAYLOR_SERIES_EVALUATOR_DEFINES_SVH
`define TAYLOR_SERIES_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define TSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tse_pkg.sv @@
// types, codes and constants of the taylor series evaluator
// no dependencies; imported by every rtl module of the block
package tse_pkg;

    localparam int MAX_TERMS = 64;
    localparam int DIV_W     = 14;   // largest divisor 126*127 fits
    localparam int CNT_W     = 7;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef logic [2:0] t_fn;
    localparam t_fn FN_SIN  = 3'd0;
    localparam t_fn FN_COS  = 3'd1;
    localparam t_fn FN_EXP  = 3'd2;
    localparam t_fn FN_COSH = 3'd3;
    localparam t_fn FN_SINH = 3'd4;

    typedef logic [3:0] t_op;
    localparam t_op OP_IDLE    = 4'd0;
    localparam t_op OP_LOAD    = 4'd1;
    localparam t_op OP_MUL_LO  = 4'd2;
    localparam t_op OP_MUL_HI  = 4'd3;
    localparam t_op OP_MUL_FIN = 4'd4;
    localparam t_op OP_DIVISOR = 4'd5;
    localparam t_op OP_DIV_GO  = 4'd6;
    localparam t_op OP_TERM    = 4'd7;
    localparam t_op OP_EMIT    = 4'd8;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MAX_TERMS = 2'd0;
    localparam t_reg_idx REG_TOL_DIGITS = 2'd1;
    localparam t_reg_idx REG_LIST_MODE = 2'd2;

    typedef struct packed {
        t_op              op;
        t_fn              fn;
        logic [CNT_W-1:0] idx;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic below_eps;
    } t_dp_stat;

    // round(2^32 / 10^digits)
    function automatic logic [32:0] tse_eps(input logic [3:0] digits);
        logic [32:0] e;
        unique case (digits)
            4'd0:    e = 33'd4294967296;
            4'd1:    e = 33'd429496730;
            4'd2:    e = 33'd42949673;
            4'd3:    e = 33'd4294967;
            4'd4:    e = 33'd429497;
            4'd5:    e = 33'd42950;
            4'd6:    e = 33'd4295;
            4'd7:    e = 33'd429;
            4'd8:    e = 33'd43;
            default: e = 33'd4;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/taylor_series_evaluator.sv @@
// top level of the taylor series evaluator: apb registers, controller, datapath
// depends on tse_pkg, tse_ctrl, tse_datapath
//
// channel   direction  handshake                     payload
// command   in         start high while busy low     i_command, i_x_value
// result    out        o_valid one-cycle strobe      o_partial_sum, o_terms_used, o_last
// config    in/out     apb write psel&penable&pwrite paddr, pwdata, prdata
//
// one item at a time; term 0 is a load, then a check
// each further term for sin/cos/cosh/sinh: two multiplies (low half, high half, finish)
//   on the shared 32x32 multiplier, divisor, divider start, divide wait,
//   check; exp has one multiply
// the result of an item is registered from its last check
// reset is synchronous and active low; registers return to max_terms 20,
//   tolerance_digits 6, list_mode 0; the results cannot be stalled
module taylor_series_evaluator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command transaction
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_command,
    input  logic signed [31:0]        i_x_value,
    // result transaction
    output logic                      o_valid,
    output logic signed [63:0]        o_partial_sum,
    output logic [6:0]                o_terms_used,
    output logic                      o_last,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import tse_pkg::*;

    // configuration registers
    logic [6:0] r_max_terms;
    logic [3:0] r_tol_digits;
    logic       r_list_mode;

    t_reg_idx   reg_idx;
    logic       cfg_wr;

    // effective limits after clamping
    logic [CNT_W-1:0] n_terms_eff;
    logic [3:0]       eps_sel;

    t_dp_cmd    cmd;
    t_dp_stat   stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_terms  <= 7'd20;
            r_tol_digits <= 4'd6;
            r_list_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MAX_TERMS:  r_max_terms  <= pwdata[6:0];
                REG_TOL_DIGITS: r_tol_digits <= pwdata[3:0];
                REG_LIST_MODE:  r_list_mode  <= pwdata[0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_TERMS:  prdata = {25'd0, r_max_terms};
            REG_TOL_DIGITS: prdata = {28'd0, r_tol_digits};
            REG_LIST_MODE:  prdata = {31'd0, r_list_mode};
            default:        prdata = 32'd0;
        endcase
    end

    // zero terms acts as one, anything past the limit acts as the limit
    always_comb begin
        priority if (r_max_terms == 7'd0) begin
            n_terms_eff = CNT_W'(1);
        end else if (r_max_terms > CNT_W'(MAX_TERMS)) begin
            n_terms_eff = CNT_W'(MAX_TERMS);
        end else begin
            n_terms_eff = r_max_terms;
        end
    end

    // tolerance tops out at nine digits
    assign eps_sel = (r_tol_digits > 4'd9) ? 4'd9 : r_tol_digits;

    tse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_n_terms   (n_terms_eff),
        .i_list_mode (r_list_mode),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    tse_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_x_value     (i_x_value),
        .i_eps_sel     (eps_sel),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_partial_sum (o_partial_sum),
        .o_terms_used  (o_terms_used),
        .o_last        (o_last)
    );

endmodule

@@ rtl/tse_divider.sv @@
// radix-16 restoring divider: 64-bit dividend by 14-bit divisor, 4 bits a cycle
// depends on tse_pkg
module tse_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_dividend,
    input  logic [tse_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [63:0]               o_quotient
);
    import tse_pkg::*;

    localparam int STEPS = 4;
    localparam int ITERS = 64 / STEPS;
    localparam int IT_W  = $clog2(ITERS);

    logic [63:0]      r_num;
    logic [63:0]      r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [IT_W-1:0]  r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DIV_W-1:0] n_rem;
    logic [STEPS-1:0] n_qbits;

    always_comb begin
        logic [DIV_W:0] t;
        n_rem = r_rem;
        n_qbits = '0;
        for (int k = 0; k < STEPS; k++) begin
            t = {n_rem, r_num[63-k]};
            if (t >= {1'b0, r_den}) begin
                t = t - {1'b0, r_den};
                n_qbits[STEPS-1-k] = 1'b1;
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= IT_W'(ITERS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_run) begin
            r_num <= {r_num[63-STEPS:0], {STEPS{1'b0}}};
            r_rem <= n_rem;
            r_quo <= {r_quo[63-STEPS:0], n_qbits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/tse_datapath.sv @@
// datapath: term and sum registers, shared 32x32 multiplier, divisor and divider
// depends on tse_pkg and tse_divider
module tse_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tse_pkg::t_dp_cmd          i_cmd,
    input  logic signed [31:0]        i_x_value,
    input  logic [3:0]                i_eps_sel,
    output tse_pkg::t_dp_stat         o_stat,
    output logic                      o_valid,
    output logic signed [63:0]        o_partial_sum,
    output logic [tse_pkg::CNT_W-1:0] o_terms_used,
    output logic                      o_last
);
    import tse_pkg::*;

    logic [31:0]      r_xa;
    logic             r_xneg;
    logic [63:0]      r_mag;
    logic             r_neg;
    logic [63:0]      r_sum;
    logic [63:0]      r_plo;
    logic [63:0]      r_phi;
    logic [DIV_W-1:0] r_den;

    logic             r_out_valid;
    logic [63:0]      r_out_sum;
    logic [CNT_W-1:0] r_out_terms;
    logic             r_out_last;

    logic [31:0]      x_bits;
    logic [31:0]      load_xa;
    logic             load_xneg;
    logic [31:0]      mul_a;
    logic [63:0]      prod;
    logic [63:0]      lo_rnd;
    logic [63:0]      mul_r;
    logic [63:0]      mul_mag;
    logic [7:0]       two_i;
    logic [15:0]      den_odd;
    logic [15:0]      den_even;
    logic [DIV_W-1:0] n_den;
    logic             div_done;
    logic [63:0]      div_q;
    logic             term_neg;
    logic [63:0]      term_s;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            s = a[63] ? {1'b1, 63'd0} : MAG_MAX;
        end
        return s;
    endfunction

    // argument magnitude; the most negative value keeps 2^31
    assign x_bits    = i_x_value;
    assign load_xneg = x_bits[31];
    assign load_xa   = load_xneg ? (32'd0 - x_bits) : x_bits;

    // one multiplier, low half then high half of the magnitude
    assign mul_a = (i_cmd.op == OP_MUL_HI) ? r_mag[63:32] : r_mag[31:0];
    assign prod  = mul_a * r_xa;

    // round to nearest at bit 27, saturate
    assign lo_rnd  = (r_plo + 64'h0000_0000_0400_0000) >> 27;
    assign mul_r   = {r_phi[58:0], 5'd0} + lo_rnd;
    assign mul_mag = (r_phi >= 64'h0400_0000_0000_0000 || mul_r[63]) ? MAG_MAX : mul_r;

    // divisor of the recurrence
    assign two_i    = {i_cmd.idx, 1'b0};
    assign den_odd  = two_i * (two_i + 8'd1);
    assign den_even = (two_i - 8'd1) * two_i;

    always_comb begin
        unique case (i_cmd.fn)
            FN_SIN, FN_SINH: n_den = den_odd[DIV_W-1:0];
            FN_COS, FN_COSH: n_den = den_even[DIV_W-1:0];
            default:         n_den = DIV_W'(i_cmd.idx);
        endcase
    end

    tse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_GO),
        .i_dividend (r_mag + 64'(r_den >> 1)),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sign of the new term
    always_comb begin
        unique case (i_cmd.fn)
            FN_EXP:         term_neg = r_neg ^ r_xneg;
            FN_SIN, FN_COS: term_neg = !r_neg;
            default:        term_neg = r_neg;
        endcase
    end
    assign term_s = term_neg ? (64'd0 - div_q) : div_q;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_xa   <= load_xa;
                r_xneg <= load_xneg;
                if (i_cmd.fn == FN_SIN || i_cmd.fn == FN_SINH) begin
                    r_mag <= {27'd0, load_xa, 5'd0};
                    r_neg <= load_xneg;
                    r_sum <= load_xneg ? (64'd0 - {27'd0, load_xa, 5'd0})
                                       : {27'd0, load_xa, 5'd0};
                end else begin
                    r_mag <= ONE_Q32;
                    r_neg <= 1'b0;
                    r_sum <= ONE_Q32;
                end
            end
            OP_MUL_LO:  r_plo <= prod;
            OP_MUL_HI:  r_phi <= prod;
            OP_MUL_FIN: r_mag <= mul_mag;
            OP_DIVISOR: r_den <= n_den;
            OP_TERM: begin
                r_mag <= div_q;
                r_neg <= term_neg && (div_q != 64'd0);
                r_sum <= sat_add(r_sum, term_s);
            end
            OP_EMIT: begin
                r_out_sum   <= r_sum;
                r_out_terms <= i_cmd.idx + 1'b1;
                r_out_last  <= i_cmd.last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.op == OP_EMIT);
        end
    end

    assign o_stat.div_done  = div_done;
    assign o_stat.below_eps = (r_mag <= 64'(tse_eps(i_eps_sel)));

    assign o_valid       = r_out_valid;
    assign o_partial_sum = r_out_sum;
    assign o_terms_used  = r_out_terms;
    assign o_last        = r_out_last;

endmodule

@@ rtl/tse_ctrl.sv @@
// controller: sequences load, multiplies, divide, accumulate and emit per term
// depends on tse_pkg and taylor_series_evaluator_defines.svh
`include "taylor_series_evaluator_defines.svh"

module tse_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  tse_pkg::t_fn              i_command,
    input  logic [tse_pkg::CNT_W-1:0] i_n_terms,
    input  logic                      i_list_mode,
    input  tse_pkg::t_dp_stat         i_stat,
    output tse_pkg::t_dp_cmd          o_cmd,
    output logic                      o_busy
);
    import tse_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_MUL_LO   = 3'd2;
    localparam logic [2:0] ST_MUL_HI   = 3'd3;
    localparam logic [2:0] ST_MUL_FIN  = 3'd4;
    localparam logic [2:0] ST_DIVISOR  = 3'd5;
    localparam logic [2:0] ST_DIV_GO   = 3'd6;
    localparam logic [2:0] ST_DIV_WAIT = 3'd7;

    logic [2:0]       r_state, n_state;
    t_fn              r_fn, n_fn;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pass, n_pass;
    logic [CNT_W-1:0] idx_next;
    logic             stop;

    assign idx_next = r_idx + 1'b1;
    assign stop     = (idx_next >= i_n_terms) || (!i_list_mode && i_stat.below_eps);

    always_comb begin
        n_state = r_state;
        n_fn    = r_fn;
        n_idx   = r_idx;
        n_pass  = r_pass;
        o_cmd.op   = OP_IDLE;
        o_cmd.fn   = r_fn;
        o_cmd.idx  = r_idx;
        o_cmd.last = stop;
        unique case (r_state)
            ST_IDLE: begin
                // unknown function codes are dropped
                if (i_start && i_command <= FN_SINH) begin
                    o_cmd.op = OP_LOAD;
                    o_cmd.fn = i_command;
                    n_fn     = i_command;
                    n_idx    = '0;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_list_mode || stop) begin
                    o_cmd.op = OP_EMIT;
                end
                if (stop) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = idx_next;
                    n_pass  = 1'b0;
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = ST_MUL_FIN;
            end
            ST_MUL_FIN: begin
                o_cmd.op = OP_MUL_FIN;
                if (r_fn == FN_EXP || r_pass) begin
                    n_state = ST_DIVISOR;
                end else begin
                    n_pass  = 1'b1;
                    n_state = ST_MUL_LO;
                end
            end
            ST_DIVISOR: begin
                o_cmd.op = OP_DIVISOR;
                n_state  = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_TERM;
                    n_state  = ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fn    <= FN_SIN;
            r_idx   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fn    <= n_fn;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `TSE_ASSERT_NXT(a_last_ends_item, i_clk, i_rst_n, (o_cmd.op == OP_EMIT) && o_cmd.last, r_state == ST_IDLE, "final result did not end the item")
    `TSE_ASSERT_NXT(a_div_wait_holds, i_clk, i_rst_n, (r_state == ST_DIV_WAIT) && !i_stat.div_done, r_state == ST_DIV_WAIT, "left divide wait without quotient")
    `TSE_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_state != ST_IDLE, r_idx < CNT_W'(MAX_TERMS), "term index beyond limit")

endmodule

@@ tb/sv/taylor_series_checker.sv @@
// checker for the taylor series evaluator: tracks the registers, predicts every sum
// and compares the result strobes field by field; depends on tse_pkg
module taylor_series_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_x_value,
    input  logic               i_valid,
    input  logic signed [63:0] i_partial_sum,
    input  logic [6:0]         i_terms_used,
    input  logic               i_last,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic [31:0]        i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    localparam logic [63:0] MAG_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [63:0] partial_sum;
        logic [6:0]         terms_used;
        logic               last;
    } t_sum_result;

    // register shadows
    logic [6:0] cfg_terms;
    logic [3:0] cfg_digits;
    logic       cfg_list;

    // series state after the latest argument
    logic signed [63:0] series_term;
    logic signed [63:0] series_sum;
    logic [6:0]         series_count;

    t_sum_result expected_sums[$];
    int          fails   = 0;
    int          results = 0;

    // round(2^32 / 10^digits), digits above 9 clamp to 9
    function automatic logic [63:0] tolerance_of(input logic [3:0] digits);
        case (digits)
            4'd0:    return 64'd4294967296;
            4'd1:    return 64'd429496730;
            4'd2:    return 64'd42949673;
            4'd3:    return 64'd4294967;
            4'd4:    return 64'd429497;
            4'd5:    return 64'd42950;
            4'd6:    return 64'd4295;
            4'd7:    return 64'd429;
            4'd8:    return 64'd43;
            default: return 64'd4;
        endcase
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
        logic [63:0] c;
        c = (m > MAG_CAP) ? MAG_CAP : m;
        return neg ? -c : c;
    endfunction

    // round(m * xa / 2^27), capped
    function automatic logic [63:0] scale_mag(input logic [63:0] m, input logic [31:0] xa);
        logic [127:0] p;
        p = 128'(m) * 128'(xa);
        p = (p + (128'd1 << 26)) >> 27;
        return (p > 128'(MAG_CAP)) ? MAG_CAP : p[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s[64] != s[63]) begin
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    task automatic predict_series(input logic [2:0] fn, input logic [31:0] xbits);
        logic               xneg;
        logic [31:0]        xa;
        logic [63:0]        eps;
        logic [63:0]        mag;
        logic [63:0]        divisor;
        logic               neg;
        logic               stop;
        logic               odd_fn;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        t_sum_result        r;
        int                 limit;
        int                 k;
        if (fn > FN_SINH) begin
            return;
        end
        xneg   = xbits[31];
        xa     = xneg ? -xbits : xbits;
        odd_fn = (fn == FN_SIN) || (fn == FN_SINH);
        limit  = (cfg_terms == 0) ? 1 : (cfg_terms > MAX_TERMS) ? MAX_TERMS : int'(cfg_terms);
        eps    = tolerance_of(cfg_digits);
        term   = '0;
        sum    = '0;
        for (k = 0; k < limit; k++) begin
            if (k == 0) begin
                term = odd_fn ? signed_of({27'd0, xa, 5'd0}, xneg) : 64'sh1_0000_0000;
                sum  = term;
            end else begin
                mag = scale_mag(magnitude(term), xa);
                neg = term[63];
                if (fn == FN_EXP) begin
                    neg     = neg ^ xneg;
                    divisor = 64'(k);
                end else begin
                    mag     = scale_mag(mag, xa);
                    divisor = odd_fn ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
                end
                mag = (mag + divisor / 2) / divisor;
                if (fn == FN_SIN || fn == FN_COS) begin
                    neg = !neg;
                end
                term = signed_of(mag, neg);
                sum  = sat_add(sum, term);
            end
            stop = (k + 1 >= limit) || (!cfg_list && magnitude(term) <= eps);
            if (cfg_list || stop) begin
                r.partial_sum = sum;
                r.terms_used  = 7'(k + 1);
                r.last        = stop;
                expected_sums.push_back(r);
            end
            if (stop) begin
                break;
            end
        end
        series_term  = term;
        series_sum   = sum;
        series_count = 7'(k + 1);
    endtask

    function automatic logic [31:0] register_value(input t_reg_idx idx);
        case (idx)
            REG_MAX_TERMS:  return {25'd0, cfg_terms};
            REG_TOL_DIGITS: return {28'd0, cfg_digits};
            REG_LIST_MODE:  return {31'd0, cfg_list};
            default:        return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_sum_result want;
        logic [31:0] rd_want;
        if (!i_rst_n) begin
            cfg_terms    = 7'd20;
            cfg_digits   = 4'd6;
            cfg_list     = 1'b0;
            series_term  = '0;
            series_sum   = '0;
            series_count = '0;
            expected_sums.delete();
        end else begin
            // apb access phase
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[3:2]))
                        REG_MAX_TERMS:  cfg_terms  = i_pwdata[6:0];
                        REG_TOL_DIGITS: cfg_digits = i_pwdata[3:0];
                        REG_LIST_MODE:  cfg_list   = i_pwdata[0];
                        default: ;
                    endcase
                end else begin
                    rd_want = register_value(t_reg_idx'(i_paddr[3:2]));
                    if (i_prdata !== rd_want) begin
                        $error("prdata: expected %0d, actual %0d", rd_want, i_prdata);
                        fails++;
                    end
                end
            end
            if (i_valid) begin
                results++;
                if (expected_sums.size() == 0) begin
                    $error("unexpected result: partial_sum %0d terms_used %0d last %0d",
                           i_partial_sum, i_terms_used, i_last);
                    fails++;
                end else begin
                    want = expected_sums.pop_front();
                    if (i_partial_sum !== want.partial_sum) begin
                        $error("partial_sum: expected %0d, actual %0d",
                               want.partial_sum, i_partial_sum);
                        fails++;
                    end
                    if (i_terms_used !== want.terms_used) begin
                        $error("terms_used: expected %0d, actual %0d",
                               want.terms_used, i_terms_used);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_series(i_command, i_x_value);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= expected_sums.size();
        o_result_count <= results;
    end

endmodule

@@ tb/sv/tb_taylor_series_evaluator.sv @@
// testbench top for the taylor series evaluator: clock, reset, commands and apb traffic
// depends on tse_pkg, taylor_series_evaluator and taylor_series_checker
module tb_taylor_series_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    // highest command code the port can carry; codes above sinh are ignored
    localparam logic [2:0] CMD_TOP_CODE  = 3'd7;
    localparam int         SETTLE_CYCLES = 2000;
    localparam int         CYCLE_LIMIT   = 4_000_000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [2:0]         i_command = '0;
    logic signed [31:0] i_x_value = '0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [3:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;

    logic               busy;
    logic               o_valid;
    logic signed [63:0] o_partial_sum;
    logic [6:0]         o_terms_used;
    logic               o_last;
    logic [31:0]        prdata;
    logic               pready;

    int fails;
    int pending;
    int results;
    int commands_sent = 0;
    int settings_used = 1;
    int cycle_count   = 0;

    always #1 i_clk = ~i_clk;

    taylor_series_evaluator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_x_value     (i_x_value),
        .o_valid       (o_valid),
        .o_partial_sum (o_partial_sum),
        .o_terms_used  (o_terms_used),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // watches both channels and the register port, predicts and compares
    taylor_series_checker u_series_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_x_value      (i_x_value),
        .i_valid        (o_valid),
        .i_partial_sum  (o_partial_sum),
        .i_terms_used   (o_terms_used),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fails),
        .o_pending      (pending),
        .o_result_count (results)
    );

    // argument mix: full range, within +-2.0, tiny values and the corners
    function automatic logic [31:0] pick_x();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom();
            5, 6, 7: begin
                v = $urandom_range(0, 32'h1000_0000);
                if ($urandom_range(0, 1) != 0) begin
                    v = -v;
                end
            end
            8: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3:       v = 32'h0800_0000;   // +1.0
                    4:       v = 32'hF800_0000;   // -1.0
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v = $urandom_range(0, 255);
                if ($urandom_range(0, 1) != 0) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // mostly legal functions, now and then an ignored code
    function automatic logic [2:0] pick_command();
        if ($urandom_range(0, 9) == 0) begin
            return 3'($urandom_range(FN_SINH + 1, CMD_TOP_CODE));
        end
        return 3'($urandom_range(FN_SIN, FN_SINH));
    endfunction

    // one command transaction; start is lowered only when a gap follows,
    // so a back-to-back item never sees two assignments in one step
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] x, input bit no_gaps);
        int gap;
        bit drain;
        gap   = no_gaps ? 0 : $urandom_range(0, 18);
        drain = ($urandom_range(0, 29) == 0);
        if (drain && gap == 0) begin
            gap = 1;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // hold off until the block has delivered everything owed
        if (drain) begin
            while (pending != 0) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_x_value <= x;
        do @(posedge i_clk); while (busy);
        commands_sent++;
    endtask

    // apb setup then access; psel stays up so transfers can run back to back
    task automatic apb_access(input logic wr, input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // drain, let the block settle, then reprogram and read back every register
    task automatic apply_settings(input logic [6:0] terms, input logic [3:0] digits,
                                  input logic listing);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // unused upper bits carry noise
        apb_access(1'b1, REG_MAX_TERMS,  ($urandom() & ~32'h7F) | 32'(terms));
        apb_access(1'b1, REG_TOL_DIGITS, ($urandom() & ~32'hF)  | 32'(digits));
        apb_access(1'b1, REG_LIST_MODE,  ($urandom() & ~32'h1)  | 32'(listing));
        apb_access(1'b0, REG_MAX_TERMS,  '0);
        apb_access(1'b0, REG_TOL_DIGITS, '0);
        apb_access(1'b0, REG_LIST_MODE,  '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // ignored codes do not count toward the phase size
    task automatic run_random(input int count, input bit no_gaps);
        int         legal;
        logic [2:0] cmd;
        legal = 0;
        while (legal < count) begin
            cmd = pick_command();
            send_command(cmd, pick_x(), no_gaps);
            if (cmd <= FN_SINH) begin
                legal++;
            end
        end
    endtask

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [31:0] corner_x [4];
        corner_x = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0800_0000};

        // reset held at the start, then released
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings: every function at zero, both
        // extremes and +1.0, -1.0 for sin and exp, then the ignored codes
        for (int f = FN_SIN; f <= FN_SINH; f++) begin
            for (int j = 0; j < 4; j++) begin
                send_command(3'(f), corner_x[j], 1'b0);
            end
        end
        send_command(FN_SIN, 32'hF800_0000, 1'b0);
        send_command(FN_EXP, 32'hF800_0000, 1'b0);
        for (int c = FN_SINH + 1; c <= CMD_TOP_CODE; c++) begin
            send_command(3'(c), $urandom(), 1'b0);
        end

        // zero term limit acts as one, loosest tolerance
        apply_settings(7'd0, 4'd0, 1'b0);
        run_random(40, 1'b0);
        // limit above the maximum, digits above nine
        apply_settings(7'd127, 4'd15, 1'b0);
        run_random(40, 1'b0);
        // every partial sum up to the full 64 terms
        apply_settings(7'd64, 4'd9, 1'b1);
        run_random(12, 1'b0);
        // single-term listing, back to back
        apply_settings(7'd1, 4'd3, 1'b1);
        run_random(45, 1'b1);
        apply_settings(7'd8, 4'd2, 1'b1);
        run_random(45, 1'b0);
        apply_settings(7'd12, 4'd6, 1'b0);
        run_random(45, 1'b1);
        // random settings, mostly short series
        repeat (4) begin
            apply_settings(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(1, 16)),
                           4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            run_random(40, $urandom_range(0, 3) == 0);
        end

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d command transactions over %0d register settings", commands_sent,
                 settings_used);
        $display("checked %0d result transactions, all functions, both modes", results);
        if (fails == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
